@@ rtl/tmpl_tok_pkg.sv @@
// Shared types, token codes, character codes and lookup functions for the template tokenizer.
package tmpl_tok_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int FIELD_BITS      = 24;
    localparam int TYPE_BITS       = 6;
    localparam int KW_DEPTH        = 15;
    localparam int KW_COUNT        = 11;
    localparam int KW_WORD_BITS    = 8 * KW_DEPTH;

    // token codes
    localparam logic [TYPE_BITS-1:0] TT_TEXT       = 6'd0;
    localparam logic [TYPE_BITS-1:0] TT_NEWLINE    = 6'd1;
    localparam logic [TYPE_BITS-1:0] TT_EOF        = 6'd2;
    localparam logic [TYPE_BITS-1:0] TT_IDENT      = 6'd3;
    localparam logic [TYPE_BITS-1:0] TT_NUMBER     = 6'd4;
    localparam logic [TYPE_BITS-1:0] TT_STRING     = 6'd5;
    localparam logic [TYPE_BITS-1:0] TT_INCOMPLETE = 6'd6;
    localparam logic [TYPE_BITS-1:0] TT_COMMA      = 6'd7;
    localparam logic [TYPE_BITS-1:0] TT_DOT        = 6'd8;
    localparam logic [TYPE_BITS-1:0] TT_STAR       = 6'd9;
    localparam logic [TYPE_BITS-1:0] TT_SLASH      = 6'd10;
    localparam logic [TYPE_BITS-1:0] TT_LPAREN     = 6'd11;
    localparam logic [TYPE_BITS-1:0] TT_RPAREN     = 6'd12;
    localparam logic [TYPE_BITS-1:0] TT_LBRACK     = 6'd13;
    localparam logic [TYPE_BITS-1:0] TT_RBRACK     = 6'd14;
    localparam logic [TYPE_BITS-1:0] TT_SEMI       = 6'd15;
    localparam logic [TYPE_BITS-1:0] TT_PLUS       = 6'd16;
    localparam logic [TYPE_BITS-1:0] TT_INC        = 6'd17;
    localparam logic [TYPE_BITS-1:0] TT_MINUS      = 6'd18;
    localparam logic [TYPE_BITS-1:0] TT_DEC        = 6'd19;
    localparam logic [TYPE_BITS-1:0] TT_LT         = 6'd20;
    localparam logic [TYPE_BITS-1:0] TT_LE         = 6'd21;
    localparam logic [TYPE_BITS-1:0] TT_GT         = 6'd22;
    localparam logic [TYPE_BITS-1:0] TT_GE         = 6'd23;
    localparam logic [TYPE_BITS-1:0] TT_OR         = 6'd24;
    localparam logic [TYPE_BITS-1:0] TT_AND        = 6'd25;
    localparam logic [TYPE_BITS-1:0] TT_ASSIGN     = 6'd26;
    localparam logic [TYPE_BITS-1:0] TT_EQ         = 6'd27;
    localparam logic [TYPE_BITS-1:0] TT_NOT        = 6'd28;
    localparam logic [TYPE_BITS-1:0] TT_NE         = 6'd29;
    localparam logic [TYPE_BITS-1:0] TT_KW_BASE    = 6'd30;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    typedef struct packed {
        logic [TYPE_BITS-1:0]  ttype;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] length;
        logic [FIELD_BITS-1:0] line;
        logic [FIELD_BITS-1:0] column;
        logic                  after_switch;
        logic                  last;
    } token_t;

    // keywords, first character in the top byte, zero padded
    localparam logic [KW_WORD_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        {"if",              {13{8'h00}}},
        {"end",             {12{8'h00}}},
        {"for",             {12{8'h00}}},
        {"foreach",         {8{8'h00}}},
        {"in",              {13{8'h00}}},
        {"ignore", "_new_line"},
        {"define",          {9{8'h00}}},
        {"definitions",     {4{8'h00}}},
        {"begin", "_tab",   {6{8'h00}}},
        {"breakpoint",      {5{8'h00}}},
        {"has", "_attribute", {2{8'h00}}}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd2, 4'd3, 4'd3, 4'd7, 4'd2, 4'd15, 4'd6, 4'd11, 4'd9, 4'd10, 4'd13
    };

    function automatic logic [TYPE_BITS-1:0] keyword_type(
        input logic [KW_WORD_BITS-1:0] word,
        input logic                    len_ok,
        input logic [3:0]              len
    );
        logic [TYPE_BITS-1:0]    r;
        logic [KW_WORD_BITS-1:0] m;
        r = TT_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            m = {KW_WORD_BITS{1'b1}} << (8 * (KW_DEPTH - int'(KW_LEN[k])));
            if (len_ok && len == KW_LEN[k] && (word & m) == KW_TEXT[k]) begin
                r = TT_KW_BASE + TYPE_BITS'(k);
            end
        end
        return r;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    function automatic logic is_delim(input logic [7:0] b);
        return b == CH_LF || b == CH_COMMA || b == CH_DOT || b == CH_PLUS ||
               b == CH_MINUS || b == CH_STAR || b == CH_SLASH || b == CH_LPAREN ||
               b == CH_RPAREN || b == CH_LBRACK || b == CH_RBRACK || b == CH_SEMI ||
               b == CH_NUL || b == CH_CR || b == CH_TAB || b == CH_BANG ||
               b == CH_EQUAL || b == CH_LT || b == CH_GT || b == CH_SPACE ||
               b == CH_DOLLAR;
    endfunction

    // code of a one-character operator, TT_TEXT if none
    function automatic logic [TYPE_BITS-1:0] single_op(input logic [7:0] b);
        logic [TYPE_BITS-1:0] r;
        unique case (b)
            CH_COMMA:  r = TT_COMMA;
            CH_DOT:    r = TT_DOT;
            CH_STAR:   r = TT_STAR;
            CH_SLASH:  r = TT_SLASH;
            CH_LPAREN: r = TT_LPAREN;
            CH_RPAREN: r = TT_RPAREN;
            CH_LBRACK: r = TT_LBRACK;
            CH_RBRACK: r = TT_RBRACK;
            CH_SEMI:   r = TT_SEMI;
            default:   r = TT_TEXT;
        endcase
        return r;
    endfunction

    // one-character form of an operator that needs lookahead, TT_TEXT if none
    function automatic logic [TYPE_BITS-1:0] pend_single(input logic [7:0] b);
        logic [TYPE_BITS-1:0] r;
        unique case (b)
            CH_PLUS:  r = TT_PLUS;
            CH_MINUS: r = TT_MINUS;
            CH_LT:    r = TT_LT;
            CH_GT:    r = TT_GT;
            CH_BAR:   r = TT_OR;
            CH_AMP:   r = TT_AND;
            CH_EQUAL: r = TT_ASSIGN;
            CH_BANG:  r = TT_NOT;
            default:  r = TT_TEXT;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pair_second(input logic [7:0] p);
        logic [7:0] r;
        if (p == CH_PLUS || p == CH_MINUS || p == CH_BAR || p == CH_AMP) begin
            r = p;
        end
        else begin
            r = CH_EQUAL;
        end
        return r;
    endfunction

    function automatic logic [TYPE_BITS-1:0] pair_code(input logic [7:0] p);
        logic [TYPE_BITS-1:0] r;
        unique case (p)
            CH_PLUS:  r = TT_INC;
            CH_MINUS: r = TT_DEC;
            CH_LT:    r = TT_LE;
            CH_GT:    r = TT_GE;
            CH_BAR:   r = TT_OR;
            CH_AMP:   r = TT_AND;
            CH_EQUAL: r = TT_EQ;
            default:  r = TT_NE;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/template_two_mode_tokenizer_unit.sv @@
// Template tokenizer: scans file bytes in text and expression modes and emits tokens.
//
// Input channel: byte_req with byte_valid/byte_stall, one file byte per request,
// a zero byte ends the file. Output channel: one token per request on
// token_type .. last_of_run with token_valid/token_stall.
// Each byte is decoded in the cycle it is accepted; its tokens (zero, one or
// two) land in a three-entry output queue, registered, whose head drives the
// ports. A byte can be taken every cycle while the queue holds at most one
// token; a byte that yields two tokens sends them out one at a time through
// the single output port.
// Operators that may have two characters are held until the next byte, and an
// identifier or keyword is emitted on the delimiter that follows it.
// Reset (rst_n low, asynchronous) clears the scanner to text mode at offset 0,
// line 1, column 1 and empties the queue; the end-of-file byte returns the
// scanner to that state as well. While the receiver stalls, the queued token
// holds and byte_stall rises once two tokens are waiting.
module template_two_mode_tokenizer_unit #(
    parameter int OFFSET_BITS = tmpl_tok_pkg::OFFSET_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  byte_req,
    output logic        token_valid,
    input  logic        token_stall,
    output logic [5:0]  token_type,
    output logic [23:0] token_start,
    output logic [23:0] token_length,
    output logic [23:0] line_number,
    output logic [23:0] column_number,
    output logic        after_switch,
    output logic        last_of_run
);

    localparam int OB = OFFSET_BITS;
    localparam int FB = tmpl_tok_pkg::FIELD_BITS;
    localparam int KD = tmpl_tok_pkg::KW_DEPTH;
    localparam int QD = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEXT,
        ST_EXPR_WS,
        ST_STRING,
        ST_PEND,
        ST_IDENT
    } scan_state_t;

    scan_state_t st_reg, st_next;
    logic          expr_reg, expr_next;
    logic [OB-1:0] pos_reg, pos_next;
    logic [OB-1:0] nl_reg, nl_next;
    logic [OB-1:0] nc_reg, nc_next;
    logic [OB-1:0] ts_reg, ts_next;
    logic [OB-1:0] tl_reg, tl_next;
    logic [OB-1:0] tc_reg, tc_next;
    logic          digits_reg, digits_next;
    logic [7:0]    pend_reg, pend_next;
    logic          sw_reg, sw_next;
    logic [7:0]    kw_buf_reg [KD];
    logic [7:0]    kw_buf_next [KD];

    tmpl_tok_pkg::token_t q_reg [QD];
    tmpl_tok_pkg::token_t q_next [QD];
    logic [1:0]           q_count_reg, q_count_next;

    tmpl_tok_pkg::token_t res [2];
    logic [1:0]           n_res;
    logic                 in_fire, out_fire;
    logic                 idle_go, ws_go, eof_hit, in_str;
    logic [OB-1:0]        len;
    logic [OB-1:0]        one_ob;
    logic [tmpl_tok_pkg::KW_WORD_BITS-1:0] kw_word;
    logic [1:0]           base;

    function automatic logic [OB-1:0] sat_inc(input logic [OB-1:0] v);
        return (v == {OB{1'b1}}) ? v : v + OB'(1);
    endfunction

    function automatic logic [FB-1:0] fit(input logic [OB-1:0] v);
        logic [OB+FB-1:0] e;
        e = {{FB{1'b0}}, v};
        return e[FB-1:0];
    endfunction

    function automatic tmpl_tok_pkg::token_t make_tok(
        input logic [tmpl_tok_pkg::TYPE_BITS-1:0] ttype,
        input logic [OB-1:0] start,
        input logic [OB-1:0] length,
        input logic [OB-1:0] line,
        input logic [OB-1:0] col,
        input logic          sw
    );
        tmpl_tok_pkg::token_t t;
        t.ttype        = ttype;
        t.start        = fit(start);
        t.length       = fit(length);
        t.line         = fit(line);
        t.column       = fit(col);
        t.after_switch = sw;
        t.last         = 1'b0;
        return t;
    endfunction

    assign in_fire     = byte_valid && !byte_stall;
    assign token_valid = q_count_reg != 2'd0;
    assign out_fire    = token_valid && !token_stall;
    assign byte_stall  = q_count_reg >= 2'd2;
    assign one_ob      = OB'(1);

    assign token_type    = q_reg[0].ttype;
    assign token_start   = q_reg[0].start;
    assign token_length  = q_reg[0].length;
    assign line_number   = q_reg[0].line;
    assign column_number = q_reg[0].column;
    assign after_switch  = q_reg[0].after_switch;
    assign last_of_run   = q_reg[0].last;

    always_comb
    begin
        for (int i = 0; i < KD; i++) begin
            kw_word[(KD-1-i)*8 +: 8] = kw_buf_reg[i];
        end
    end

    // scanner: one byte per accepted request
    always_comb
    begin
        st_next     = st_reg;
        expr_next   = expr_reg;
        pos_next    = pos_reg;
        nl_next     = nl_reg;
        nc_next     = nc_reg;
        ts_next     = ts_reg;
        tl_next     = tl_reg;
        tc_next     = tc_reg;
        digits_next = digits_reg;
        pend_next   = pend_reg;
        sw_next     = sw_reg;
        kw_buf_next = kw_buf_reg;
        res[0]      = '0;
        res[1]      = '0;
        n_res       = 2'd0;
        idle_go     = 1'b0;
        ws_go       = 1'b0;
        eof_hit     = 1'b0;
        in_str      = 1'b0;
        len         = pos_reg - ts_reg;

        if (in_fire) begin
            unique case (st_reg)
                ST_IDLE:
                begin
                    idle_go = 1'b1;
                end
                ST_EXPR_WS:
                begin
                    ws_go = 1'b1;
                end
                ST_TEXT:
                begin
                    if (byte_req == tmpl_tok_pkg::CH_DOLLAR) begin
                        res[n_res[0]] = make_tok(tmpl_tok_pkg::TT_TEXT, ts_next, len,
                                                 tl_next, tc_next, sw_next);
                        n_res     = n_res + 2'd1;
                        sw_next   = 1'b1;
                        expr_next = 1'b1;
                        st_next   = ST_IDLE;
                    end
                    else if (byte_req == tmpl_tok_pkg::CH_LF ||
                             byte_req == tmpl_tok_pkg::CH_NUL) begin
                        res[n_res[0]] = make_tok(tmpl_tok_pkg::TT_TEXT, ts_next, len,
                                                 tl_next, tc_next, sw_next);
                        n_res   = n_res + 2'd1;
                        sw_next = 1'b0;
                        st_next = ST_IDLE;
                        idle_go = 1'b1;
                    end
                end
                ST_STRING:
                begin
                    if (byte_req == tmpl_tok_pkg::CH_QUOTE) begin
                        res[n_res[0]] = make_tok(tmpl_tok_pkg::TT_STRING, ts_next, len,
                                                 tl_next, tc_next, sw_next);
                        n_res   = n_res + 2'd1;
                        sw_next = 1'b0;
                        st_next = ST_IDLE;
                    end
                    else if (byte_req == tmpl_tok_pkg::CH_NUL) begin
                        res[n_res[0]] = make_tok(tmpl_tok_pkg::TT_INCOMPLETE, ts_next, len,
                                                 tl_next, tc_next, sw_next);
                        n_res   = n_res + 2'd1;
                        sw_next = 1'b0;
                        st_next = ST_IDLE;
                        idle_go = 1'b1;
                    end
                    else begin
                        in_str = 1'b1;
                    end
                end
                ST_PEND:
                begin
                    if (byte_req == tmpl_tok_pkg::pair_second(pend_reg)) begin
                        res[n_res[0]] = make_tok(tmpl_tok_pkg::pair_code(pend_reg), ts_next,
                                                 OB'(2), tl_next, tc_next, sw_next);
                        n_res   = n_res + 2'd1;
                        sw_next = 1'b0;
                        st_next = ST_IDLE;
                    end
                    else if (pend_reg == tmpl_tok_pkg::CH_BAR ||
                             pend_reg == tmpl_tok_pkg::CH_AMP) begin
                        // lone bar or ampersand opens an identifier
                        kw_buf_next[0] = pend_reg;
                        digits_next    = 1'b0;
                        if (tmpl_tok_pkg::is_delim(byte_req)) begin
                            res[n_res[0]] = make_tok(tmpl_tok_pkg::TT_IDENT, ts_next, len,
                                                     tl_next, tc_next, sw_next);
                            n_res   = n_res + 2'd1;
                            sw_next = 1'b0;
                            st_next = ST_IDLE;
                            idle_go = 1'b1;
                        end
                        else begin
                            if (len < OB'(KD)) begin
                                kw_buf_next[len[3:0]] = byte_req;
                            end
                            st_next = ST_IDENT;
                        end
                    end
                    else begin
                        res[n_res[0]] = make_tok(tmpl_tok_pkg::pend_single(pend_reg), ts_next,
                                                 one_ob, tl_next, tc_next, sw_next);
                        n_res   = n_res + 2'd1;
                        sw_next = 1'b0;
                        st_next = ST_IDLE;
                        idle_go = 1'b1;
                    end
                end
                ST_IDENT:
                begin
                    if (tmpl_tok_pkg::is_delim(byte_req)) begin
                        res[n_res[0]] = make_tok(
                            digits_reg ? tmpl_tok_pkg::TT_NUMBER :
                                tmpl_tok_pkg::keyword_type(kw_word, len < OB'(KD + 1), len[3:0]),
                            ts_next, len, tl_next, tc_next, sw_next);
                        n_res   = n_res + 2'd1;
                        sw_next = 1'b0;
                        st_next = ST_IDLE;
                        idle_go = 1'b1;
                    end
                    else begin
                        if (len < OB'(KD)) begin
                            kw_buf_next[len[3:0]] = byte_req;
                        end
                        if (byte_req < tmpl_tok_pkg::CH_ZERO ||
                            byte_req > tmpl_tok_pkg::CH_NINE) begin
                            digits_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    st_next = ST_IDLE;
                end
            endcase

            if (idle_go) begin
                tl_next = nl_reg;
                tc_next = nc_reg;
                if (expr_next) begin
                    ws_go = 1'b1;
                end
                else if (byte_req == tmpl_tok_pkg::CH_NUL) begin
                    res[n_res[0]] = make_tok(tmpl_tok_pkg::TT_EOF, pos_reg, one_ob,
                                             tl_next, tc_next, sw_next);
                    n_res   = n_res + 2'd1;
                    sw_next = 1'b0;
                    eof_hit = 1'b1;
                end
                else if (byte_req == tmpl_tok_pkg::CH_LF) begin
                    res[n_res[0]] = make_tok(tmpl_tok_pkg::TT_NEWLINE, pos_reg, one_ob,
                                             tl_next, tc_next, sw_next);
                    n_res   = n_res + 2'd1;
                    sw_next = 1'b0;
                end
                else if (byte_req == tmpl_tok_pkg::CH_DOLLAR) begin
                    expr_next = 1'b1;
                    sw_next   = 1'b1;
                end
                else begin
                    ts_next = pos_reg;
                    st_next = ST_TEXT;
                end
            end

            // expression mode: skip white space, then start the next token
            if (ws_go) begin
                if (tmpl_tok_pkg::is_ws(byte_req)) begin
                    st_next = ST_EXPR_WS;
                end
                else begin
                    st_next = ST_IDLE;
                    if (byte_req == tmpl_tok_pkg::CH_DOLLAR) begin
                        expr_next = 1'b0;
                        sw_next   = 1'b1;
                    end
                    else if (byte_req == tmpl_tok_pkg::CH_NUL) begin
                        res[n_res[0]] = make_tok(tmpl_tok_pkg::TT_EOF, pos_reg, one_ob,
                                                 tl_next, tc_next, sw_next);
                        n_res   = n_res + 2'd1;
                        sw_next = 1'b0;
                        eof_hit = 1'b1;
                    end
                    else if (byte_req == tmpl_tok_pkg::CH_QUOTE) begin
                        ts_next = sat_inc(pos_reg);
                        st_next = ST_STRING;
                    end
                    else if (tmpl_tok_pkg::single_op(byte_req) != tmpl_tok_pkg::TT_TEXT) begin
                        res[n_res[0]] = make_tok(tmpl_tok_pkg::single_op(byte_req), pos_reg,
                                                 one_ob, tl_next, tc_next, sw_next);
                        n_res   = n_res + 2'd1;
                        sw_next = 1'b0;
                    end
                    else if (tmpl_tok_pkg::pend_single(byte_req) != tmpl_tok_pkg::TT_TEXT) begin
                        pend_next = byte_req;
                        ts_next   = pos_reg;
                        st_next   = ST_PEND;
                    end
                    else begin
                        ts_next        = pos_reg;
                        kw_buf_next[0] = byte_req;
                        digits_next    = byte_req >= tmpl_tok_pkg::CH_ZERO &&
                                         byte_req <= tmpl_tok_pkg::CH_NINE;
                        st_next        = ST_IDENT;
                    end
                end
            end

            if (n_res == 2'd2) begin
                res[1].last = 1'b1;
            end
            else if (n_res == 2'd1) begin
                res[0].last = 1'b1;
            end

            if (eof_hit) begin
                st_next     = ST_IDLE;
                expr_next   = 1'b0;
                pos_next    = '0;
                nl_next     = one_ob;
                nc_next     = one_ob;
                ts_next     = '0;
                tl_next     = '0;
                tc_next     = '0;
                digits_next = 1'b1;
                pend_next   = '0;
                sw_next     = 1'b0;
            end
            else begin
                pos_next = sat_inc(pos_reg);
                if (byte_req == tmpl_tok_pkg::CH_LF && !in_str) begin
                    nl_next = sat_inc(nl_reg);
                    nc_next = one_ob;
                end
                else begin
                    nc_next = sat_inc(nc_reg);
                end
            end
        end
    end

    // output queue: head entry drives the ports
    always_comb
    begin
        for (int i = 0; i < QD; i++) begin
            if (out_fire && i < QD - 1) begin
                q_next[i] = q_reg[(i + 1) % QD];
            end
            else begin
                q_next[i] = q_reg[i];
            end
        end
        base = q_count_reg - {1'b0, out_fire};
        if (n_res != 2'd0) begin
            q_next[base] = res[0];
        end
        if (n_res == 2'd2) begin
            q_next[base + 2'd1] = res[1];
        end
        q_count_next = base + n_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg      <= ST_IDLE;
            expr_reg    <= 1'b0;
            pos_reg     <= '0;
            nl_reg      <= OB'(1);
            nc_reg      <= OB'(1);
            ts_reg      <= '0;
            tl_reg      <= '0;
            tc_reg      <= '0;
            digits_reg  <= 1'b1;
            pend_reg    <= '0;
            sw_reg      <= 1'b0;
            q_count_reg <= 2'd0;
        end
        else begin
            st_reg      <= st_next;
            expr_reg    <= expr_next;
            pos_reg     <= pos_next;
            nl_reg      <= nl_next;
            nc_reg      <= nc_next;
            ts_reg      <= ts_next;
            tl_reg      <= tl_next;
            tc_reg      <= tc_next;
            digits_reg  <= digits_next;
            pend_reg    <= pend_next;
            sw_reg      <= sw_next;
            q_count_reg <= q_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kw_buf_reg <= kw_buf_next;
        q_reg      <= q_next;
    end

endmodule

@@ sim/template_two_mode_tokenizer_unit_test.sv @@
// Testbench for the template tokenizer: byte driver, token monitor and token predictor.
module template_two_mode_tokenizer_unit_test;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_START   = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_FILES = 5;
    localparam logic [23:0] CNT_MAX = 24'hFFFFFF;

    typedef enum logic [2:0] {
        SC_IDLE, SC_TEXT, SC_EXPR_WS, SC_STRING, SC_PEND, SC_IDENT
    } scan_t;

    logic        clk;
    logic        rst_n;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  byte_req = '0;
    logic        token_valid;
    logic        token_stall = 1'b0;
    logic [5:0]  token_type;
    logic [23:0] token_start;
    logic [23:0] token_length;
    logic [23:0] line_number;
    logic [23:0] column_number;
    logic        after_switch;
    logic        last_of_run;

    template_two_mode_tokenizer_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .byte_valid(byte_valid), .byte_stall(byte_stall), .byte_req(byte_req),
        .token_valid(token_valid), .token_stall(token_stall),
        .token_type(token_type), .token_start(token_start),
        .token_length(token_length), .line_number(line_number),
        .column_number(column_number), .after_switch(after_switch),
        .last_of_run(last_of_run)
    );

    // tokenizer state mirror
    logic        m_expr;
    scan_t       m_scan;
    logic [23:0] m_pos, m_line, m_col, m_tstart, m_tline, m_tcol;
    logic        m_digits, m_switch;
    logic [7:0]  m_pend;
    logic [7:0]  m_kw [tmpl_tok_pkg::KW_DEPTH];

    logic [7:0]           byte_queue [$];
    tmpl_tok_pkg::token_t token_queue [$];
    int   errors = 0;
    int   idle_cycles = 0;
    int   hold_off = 0;
    int   out_cycle = 0;
    int   gap_in = 0;
    int   gap_out = 0;
    logic byte_stall_s = 1'b0;
    logic byte_taken;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [23:0] sat_inc(input logic [23:0] v);
        return (v == CNT_MAX) ? v : v + 24'd1;
    endfunction

    function automatic string kw_name(input int k);
        string s;
        case (k)
            0:       s = "if";
            1:       s = "end";
            2:       s = "for";
            3:       s = "foreach";
            4:       s = "in";
            5:       s = {"ignore", "_new_line"};
            6:       s = "define";
            7:       s = "definitions";
            8:       s = {"begin", "_tab"};
            9:       s = "breakpoint";
            default: s = {"has", "_attribute"};
        endcase
        return s;
    endfunction

    function automatic logic [5:0] op_one(input logic [7:0] b);
        case (b)
            tmpl_tok_pkg::CH_COMMA:  return tmpl_tok_pkg::TT_COMMA;
            tmpl_tok_pkg::CH_DOT:    return tmpl_tok_pkg::TT_DOT;
            tmpl_tok_pkg::CH_STAR:   return tmpl_tok_pkg::TT_STAR;
            tmpl_tok_pkg::CH_SLASH:  return tmpl_tok_pkg::TT_SLASH;
            tmpl_tok_pkg::CH_LPAREN: return tmpl_tok_pkg::TT_LPAREN;
            tmpl_tok_pkg::CH_RPAREN: return tmpl_tok_pkg::TT_RPAREN;
            tmpl_tok_pkg::CH_LBRACK: return tmpl_tok_pkg::TT_LBRACK;
            tmpl_tok_pkg::CH_RBRACK: return tmpl_tok_pkg::TT_RBRACK;
            default:                 return tmpl_tok_pkg::TT_SEMI;
        endcase
    endfunction

    function automatic logic [5:0] op_pair_first(input logic [7:0] b);
        case (b)
            tmpl_tok_pkg::CH_PLUS:  return tmpl_tok_pkg::TT_PLUS;
            tmpl_tok_pkg::CH_MINUS: return tmpl_tok_pkg::TT_MINUS;
            tmpl_tok_pkg::CH_LT:    return tmpl_tok_pkg::TT_LT;
            tmpl_tok_pkg::CH_GT:    return tmpl_tok_pkg::TT_GT;
            tmpl_tok_pkg::CH_BAR:   return tmpl_tok_pkg::TT_OR;
            tmpl_tok_pkg::CH_AMP:   return tmpl_tok_pkg::TT_AND;
            tmpl_tok_pkg::CH_EQUAL: return tmpl_tok_pkg::TT_ASSIGN;
            tmpl_tok_pkg::CH_BANG:  return tmpl_tok_pkg::TT_NOT;
            default:                return tmpl_tok_pkg::TT_TEXT;
        endcase
    endfunction

    function automatic logic [7:0] op_pair_second(input logic [7:0] p);
        if (p == tmpl_tok_pkg::CH_PLUS || p == tmpl_tok_pkg::CH_MINUS ||
            p == tmpl_tok_pkg::CH_BAR || p == tmpl_tok_pkg::CH_AMP)
            return p;
        return tmpl_tok_pkg::CH_EQUAL;
    endfunction

    function automatic logic [5:0] op_pair_code(input logic [7:0] p);
        case (p)
            tmpl_tok_pkg::CH_PLUS:  return tmpl_tok_pkg::TT_INC;
            tmpl_tok_pkg::CH_MINUS: return tmpl_tok_pkg::TT_DEC;
            tmpl_tok_pkg::CH_LT:    return tmpl_tok_pkg::TT_LE;
            tmpl_tok_pkg::CH_GT:    return tmpl_tok_pkg::TT_GE;
            tmpl_tok_pkg::CH_BAR:   return tmpl_tok_pkg::TT_OR;
            tmpl_tok_pkg::CH_AMP:   return tmpl_tok_pkg::TT_AND;
            tmpl_tok_pkg::CH_EQUAL: return tmpl_tok_pkg::TT_EQ;
            default:                return tmpl_tok_pkg::TT_NE;
        endcase
    endfunction

    task automatic clear_scanner();
        m_expr = 1'b0;
        m_scan = SC_IDLE;
        m_pos = '0;
        m_line = 24'd1;
        m_col = 24'd1;
        m_tstart = '0;
        m_tline = '0;
        m_tcol = '0;
        m_digits = 1'b1;
        m_pend = '0;
        m_switch = 1'b0;
    endtask

    task automatic push_token(input logic [5:0] tt, input logic [23:0] st,
                              input logic [23:0] len, inout int cnt);
        tmpl_tok_pkg::token_t t;
        t.ttype = tt;
        t.start = st;
        t.length = len;
        t.line = m_tline;
        t.column = m_tcol;
        t.after_switch = m_switch;
        t.last = 1'b0;
        token_queue.push_back(t);
        cnt++;
        m_switch = 1'b0;
    endtask

    function automatic logic [5:0] word_type(input logic [23:0] len);
        string w;
        logic [5:0] r;
        if (m_digits)
            return tmpl_tok_pkg::TT_NUMBER;
        r = tmpl_tok_pkg::TT_IDENT;
        if (len <= tmpl_tok_pkg::KW_DEPTH)
        begin
            w = "";
            for (int i = 0; i < len; i++)
                w = {w, string'(m_kw[i])};
            for (int k = tmpl_tok_pkg::KW_COUNT - 1; k >= 0; k--)
                if (w == kw_name(k))
                    r = tmpl_tok_pkg::TT_KW_BASE + 6'(k);
        end
        return r;
    endfunction

    // predicts the tokens that one accepted byte produces
    task automatic predict_tokens(input logic [7:0] b);
        logic [23:0] pos;
        logic [23:0] len;
        int  cnt;
        bit  again, eof, in_str;
        pos = m_pos;
        cnt = 0;
        again = 1;
        eof = 0;
        in_str = 0;
        for (int pass = 0; again && pass < 8; pass++)
        begin
            again = 0;
            case (m_scan)
                SC_IDLE:
                begin
                    m_tline = m_line;
                    m_tcol = m_col;
                    if (m_expr)
                    begin
                        m_scan = SC_EXPR_WS;
                        again = 1;
                    end
                    else if (b == tmpl_tok_pkg::CH_NUL)
                    begin
                        push_token(tmpl_tok_pkg::TT_EOF, pos, 24'd1, cnt);
                        eof = 1;
                    end
                    else if (b == tmpl_tok_pkg::CH_LF)
                        push_token(tmpl_tok_pkg::TT_NEWLINE, pos, 24'd1, cnt);
                    else if (b == tmpl_tok_pkg::CH_DOLLAR)
                    begin
                        m_expr = 1'b1;
                        m_switch = 1'b1;
                    end
                    else
                    begin
                        m_tstart = pos;
                        m_scan = SC_TEXT;
                    end
                end
                SC_TEXT:
                begin
                    if (b == tmpl_tok_pkg::CH_DOLLAR)
                    begin
                        push_token(tmpl_tok_pkg::TT_TEXT, m_tstart, pos - m_tstart, cnt);
                        m_switch = 1'b1;
                        m_expr = 1'b1;
                        m_scan = SC_IDLE;
                    end
                    else if (b == tmpl_tok_pkg::CH_LF || b == tmpl_tok_pkg::CH_NUL)
                    begin
                        push_token(tmpl_tok_pkg::TT_TEXT, m_tstart, pos - m_tstart, cnt);
                        m_scan = SC_IDLE;
                        again = 1;
                    end
                end
                SC_EXPR_WS:
                begin
                    if (!(b == tmpl_tok_pkg::CH_SPACE || b == tmpl_tok_pkg::CH_TAB ||
                          b == tmpl_tok_pkg::CH_CR || b == tmpl_tok_pkg::CH_LF))
                    begin
                        m_scan = SC_IDLE;
                        if (b == tmpl_tok_pkg::CH_DOLLAR)
                        begin
                            m_expr = 1'b0;
                            m_switch = 1'b1;
                        end
                        else if (b == tmpl_tok_pkg::CH_NUL)
                        begin
                            push_token(tmpl_tok_pkg::TT_EOF, pos, 24'd1, cnt);
                            eof = 1;
                        end
                        else if (b == tmpl_tok_pkg::CH_QUOTE)
                        begin
                            m_tstart = sat_inc(pos);
                            m_scan = SC_STRING;
                        end
                        else if (b inside {tmpl_tok_pkg::CH_COMMA, tmpl_tok_pkg::CH_DOT,
                                           tmpl_tok_pkg::CH_STAR, tmpl_tok_pkg::CH_SLASH,
                                           tmpl_tok_pkg::CH_LPAREN, tmpl_tok_pkg::CH_RPAREN,
                                           tmpl_tok_pkg::CH_LBRACK, tmpl_tok_pkg::CH_RBRACK,
                                           tmpl_tok_pkg::CH_SEMI})
                            push_token(op_one(b), pos, 24'd1, cnt);
                        else if (op_pair_first(b) != tmpl_tok_pkg::TT_TEXT)
                        begin
                            m_pend = b;
                            m_tstart = pos;
                            m_scan = SC_PEND;
                        end
                        else
                        begin
                            m_tstart = pos;
                            m_digits = 1'b1;
                            m_scan = SC_IDENT;
                            again = 1;
                        end
                    end
                end
                SC_STRING:
                begin
                    if (b == tmpl_tok_pkg::CH_QUOTE)
                    begin
                        push_token(tmpl_tok_pkg::TT_STRING, m_tstart, pos - m_tstart, cnt);
                        m_scan = SC_IDLE;
                    end
                    else if (b == tmpl_tok_pkg::CH_NUL)
                    begin
                        push_token(tmpl_tok_pkg::TT_INCOMPLETE, m_tstart, pos - m_tstart,
                                   cnt);
                        m_scan = SC_IDLE;
                        again = 1;
                    end
                    else
                        in_str = 1;
                end
                SC_PEND:
                begin
                    if (b == op_pair_second(m_pend))
                    begin
                        push_token(op_pair_code(m_pend), m_tstart, 24'd2, cnt);
                        m_scan = SC_IDLE;
                    end
                    else if (m_pend == tmpl_tok_pkg::CH_BAR || m_pend == tmpl_tok_pkg::CH_AMP)
                    begin
                        m_kw[0] = m_pend;
                        m_digits = 1'b0;
                        m_scan = SC_IDENT;
                        again = 1;
                    end
                    else
                    begin
                        push_token(op_pair_first(m_pend), m_tstart, 24'd1, cnt);
                        m_scan = SC_IDLE;
                        again = 1;
                    end
                end
                default:
                begin
                    if (b inside {tmpl_tok_pkg::CH_LF, tmpl_tok_pkg::CH_COMMA,
                                  tmpl_tok_pkg::CH_DOT, tmpl_tok_pkg::CH_PLUS,
                                  tmpl_tok_pkg::CH_MINUS, tmpl_tok_pkg::CH_STAR,
                                  tmpl_tok_pkg::CH_SLASH, tmpl_tok_pkg::CH_LPAREN,
                                  tmpl_tok_pkg::CH_RPAREN, tmpl_tok_pkg::CH_LBRACK,
                                  tmpl_tok_pkg::CH_RBRACK, tmpl_tok_pkg::CH_SEMI,
                                  tmpl_tok_pkg::CH_NUL, tmpl_tok_pkg::CH_CR,
                                  tmpl_tok_pkg::CH_TAB, tmpl_tok_pkg::CH_BANG,
                                  tmpl_tok_pkg::CH_EQUAL, tmpl_tok_pkg::CH_LT,
                                  tmpl_tok_pkg::CH_GT, tmpl_tok_pkg::CH_SPACE,
                                  tmpl_tok_pkg::CH_DOLLAR})
                    begin
                        len = pos - m_tstart;
                        push_token(word_type(len), m_tstart, len, cnt);
                        m_scan = SC_IDLE;
                        again = 1;
                    end
                    else
                    begin
                        len = pos - m_tstart;
                        if (len < tmpl_tok_pkg::KW_DEPTH)
                            m_kw[len[3:0]] = b;
                        if (b < tmpl_tok_pkg::CH_ZERO || b > tmpl_tok_pkg::CH_NINE)
                            m_digits = 1'b0;
                    end
                end
            endcase
        end
        if (cnt > 0)
            token_queue[$].last = 1'b1;
        if (eof)
            clear_scanner();
        else
        begin
            m_pos = sat_inc(m_pos);
            if (b == tmpl_tok_pkg::CH_LF && !in_str)
            begin
                m_line = sat_inc(m_line);
                m_col = 24'd1;
            end
            else
                m_col = sat_inc(m_col);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    // stimulus helpers
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            byte_queue.push_back(s[i]);
    endtask

    function automatic logic [7:0] rand_expr_byte();
        string pool;
        pool = "abcxyz_019 \t\r\n,.*/()[];+-<>|&=!\"$";
        case ($urandom_range(0, 9))
            0:       return 8'($urandom_range(1, 255));
            default: return pool[$urandom_range(0, pool.len() - 1)];
        endcase
    endfunction

    task automatic add_random_file();
        int n;
        n = $urandom_range(4, 30);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 5))
                0: add_text("txt ");
                1: byte_queue.push_back(tmpl_tok_pkg::CH_LF);
                2: byte_queue.push_back(tmpl_tok_pkg::CH_DOLLAR);
                3:
                begin
                    add_text(kw_name($urandom_range(0, tmpl_tok_pkg::KW_COUNT - 1)));
                    byte_queue.push_back(tmpl_tok_pkg::CH_SPACE);
                end
                4: byte_queue.push_back(8'($urandom_range(1, 255)));
                default: byte_queue.push_back(rand_expr_byte());
            endcase
        end
        byte_queue.push_back(tmpl_tok_pkg::CH_NUL);
    endtask

    // driver: byte changes at the falling edge, gap drawn per request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall_s)
            begin
                gap_in = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 17)) : 0;
            end
            if (!byte_valid || !byte_stall_s)
            begin
                if (gap_in > 0 || byte_queue.size() == 0)
                begin
                    if (gap_in > 0)
                        gap_in--;
                    byte_valid <= 1'b0;
                end
                else
                begin
                    byte_valid <= 1'b1;
                    byte_req <= byte_queue.pop_front();
                end
            end
        end
    end

    // stall observed at the last rising edge; predictor
    always @(posedge clk)
    begin
        byte_stall_s <= byte_stall;
        byte_taken = byte_valid && !byte_stall && rst_n;
        if (!rst_n)
            clear_scanner();
        else if (byte_taken)
            predict_tokens(byte_req);
    end

    // receiver stall, with one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
            out_cycle++;
        if (out_cycle == HOLD_START)
            hold_off = HOLD_CYCLES;
        if (hold_off > 0)
        begin
            hold_off--;
            token_stall <= 1'b1;
        end
        else if (gap_out > 0)
        begin
            gap_out--;
            token_stall <= 1'b1;
        end
        else
        begin
            token_stall <= 1'b0;
            if (token_valid)
                gap_out = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 17)) : 0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        tmpl_tok_pkg::token_t w;
        if (rst_n && token_valid && !token_stall)
        begin
            if (token_queue.size() == 0)
                report_mismatch("unexpected token type", 24'(token_type), '0);
            else
            begin
                w = token_queue.pop_front();
                if (token_type !== w.ttype)
                    report_mismatch("type", 24'(token_type), 24'(w.ttype));
                if (token_start !== w.start)
                    report_mismatch("start", token_start, w.start);
                if (token_length !== w.length)
                    report_mismatch("length", token_length, w.length);
                if (line_number !== w.line)
                    report_mismatch("line", line_number, w.line);
                if (column_number !== w.column)
                    report_mismatch("column", column_number, w.column);
                if (after_switch !== w.after_switch)
                    report_mismatch("after_switch", 24'(after_switch), 24'(w.after_switch));
                if (last_of_run !== w.last)
                    report_mismatch("last", 24'(last_of_run), 24'(w.last));
            end
        end
    end

    // watchdog on cycles with no request moving
    always @(posedge clk)
    begin
        if ((byte_valid && !byte_stall) || (token_valid && !token_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: text, newline, every operator, keywords, strings, lone bar/amp
        add_text({"hi\n$ if end for foreach in ignore", "_new_line define definitions "});
        add_text({"begin", "_tab breakpoint has", "_attribute ifx 0123 a9 , . * / ( ) [ ] ; "});
        add_text("+ ++ - -- < <= > >= || && = == ! != |a &b | & \"str\n\" ");
        add_text("abcdefghijklmnopq $tail$\"open");
        byte_queue.push_back(tmpl_tok_pkg::CH_NUL);
        add_text("x");
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'h80);
        byte_queue.push_back(tmpl_tok_pkg::CH_NUL);

        while (byte_queue.size() > 0)
            @(posedge clk);

        for (int f = 0; f < RANDOM_FILES; f++)
            add_random_file();
        while (byte_queue.size() > 0 || byte_valid)
            @(posedge clk);
        while (token_queue.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/tmpl_tok_pkg.sv
rtl/template_two_mode_tokenizer_unit.sv
sim/template_two_mode_tokenizer_unit_test.sv
